FILE: src/peak_envelope_limiter_defines.svh
// ------------------------------------------------------------------------
// Peak envelope limiter assertion macros
// Concurrent checks on clk with asynchronous reset arst_n; empty for synthesis.
// ------------------------------------------------------------------------
`ifndef PEAK_ENVELOPE_LIMITER_DEFINES_SVH
`define PEAK_ENVELOPE_LIMITER_DEFINES_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define PEL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that a condition is followed by another in the next cycle
`define PEL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PEL_ASSERT(lbl, prop, msg)
`define PEL_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: src/pel_pkg.sv
// ------------------------------------------------------------------------
// Peak envelope limiter package
// Field widths, register indexes, reset values and controller interface types.
// ------------------------------------------------------------------------
package pel_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEFF_W    = 17;
	localparam int CEIL_W     = 24;
	localparam int COUNT_W    = 6;
	localparam int POS_W      = 5;
	localparam int QUO_W      = 16;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	// unity in Q1.16
	localparam logic [COEFF_W-1:0] ONE_Q16 = 17'h10000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 8'd3;

	// register reset values and channel count limit
	localparam logic [CEIL_W-1:0]  CEILING_RST = 24'h800000;
	localparam logic [COUNT_W-1:0] COUNT_RST   = 6'd2;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd32;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic load;
		logic mul;
		logic upd;
		logic div_step;
		logic gmul;
		logic fin;
	} pel_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} pel_sts_t;

endpackage

FILE: src/peak_envelope_limiter.sv
// ------------------------------------------------------------------------
// Peak envelope limiter
// Per-channel peak envelope follower with ceiling/envelope gain reduction.
// ------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream (tdata = sample, tlast = end of buffer,
//   tuser = clear envelopes first). Results leave on the m_ stream
//   (tdata = limited sample, tuser = channel, tlast = copy of input tlast).
//   Registers are written on the cfg channel, which is always ready; write
//   only while the block is idle.
//   One item is in flight at a time. The result takes a longer path when
//   gain reduction is needed: the 16-step restoring divider for
//   ceiling/envelope then runs between the envelope update and the gain.
//   A new item is accepted in the cycle after the result is loaded into
//   the output register, so a result waiting for m_tready does not block
//   input until the next result is ready to be loaded.
//   Reset clears all envelopes, the channel position and the registers to
//   their defaults. If the receiver stalls, the result is held in the output
//   register and the next finished item waits in the controller.
// ------------------------------------------------------------------------
`include "peak_envelope_limiter_defines.svh"

module peak_envelope_limiter #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,   // [23:0] sample_in
	input  logic                               s_tlast,   // last_in_buffer
	input  logic [0:0]                         s_tuser,   // [0] clear_state
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // [23:0] sample_out
	output logic                               m_tlast,   // last_out
	output logic [4:0]                         m_tuser,   // [4:0] channel
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pel_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pel_pkg::pel_cmd_t cmd;
	pel_pkg::pel_sts_t sts;
	logic signed [pel_pkg::SAMPLE_W-1:0] sample_res;

	assign cfg_ready = 1'b1;
	assign m_tdata   = sample_res;

	// sequence control
	pel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and state
	pel_dpath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  ($signed(s_tdata)),
		.last_in    (s_tlast),
		.clear_in   (s_tuser[0]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.sample_out (sample_res),
		.channel    (m_tuser),
		.last_out   (m_tlast)
	);

	// checks
	`PEL_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
	`PEL_ASSERT(a_fin_free, !cmd.fin || sts.out_free, "result loaded over an untaken one")
	`PEL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"second item accepted while one is in flight")

endmodule

FILE: src/pel_ctrl.sv
// ------------------------------------------------------------------------
// Peak envelope limiter controller
// Sequences one item: load, multiply, update, optional divide, gain, output.
// ------------------------------------------------------------------------
module pel_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pel_pkg::pel_sts_t  sts,
	output pel_pkg::pel_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOAD = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_UPD  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_GMUL = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.need_div ? S_DIV : S_GMUL;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_GMUL;
				end
			end
			S_GMUL: begin
				cmd.gmul = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/pel_dpath.sv
// ------------------------------------------------------------------------
// Peak envelope limiter datapath
// Registers, envelope store, envelope update, gain divider and output stage.
// ------------------------------------------------------------------------
module pel_dpath #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pel_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pel_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [pel_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 last_in,
	input  logic                                 clear_in,
	input  pel_pkg::pel_cmd_t                    cmd,
	output pel_pkg::pel_sts_t                    sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [pel_pkg::SAMPLE_W-1:0]  sample_out,
	output logic [pel_pkg::POS_W-1:0]            channel,
	output logic                                 last_out
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SW    = pel_pkg::SAMPLE_W;
	localparam int CW    = pel_pkg::COEFF_W;

	// configuration registers
	logic [CW-1:0]                   attack_q;
	logic [CW-1:0]                   release_q;
	logic [pel_pkg::CEIL_W-1:0]      ceiling_q;
	logic [pel_pkg::COUNT_W-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= pel_pkg::ONE_Q16;
			release_q <= pel_pkg::ONE_Q16;
			ceiling_q <= pel_pkg::CEILING_RST;
			count_q   <= pel_pkg::COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pel_pkg::REG_ATTACK:  attack_q  <= cfg_data[CW-1:0];
				pel_pkg::REG_RELEASE: release_q <= cfg_data[CW-1:0];
				pel_pkg::REG_CEILING: ceiling_q <= cfg_data[pel_pkg::CEIL_W-1:0];
				pel_pkg::REG_COUNT:   count_q   <= cfg_data[pel_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// channel position and its advance
	logic [pel_pkg::POS_W-1:0]   pos_q;
	logic [pel_pkg::COUNT_W-1:0] eff_count;
	logic [pel_pkg::COUNT_W-1:0] pos_inc;

	always_comb begin
		if (count_q == '0) begin
			eff_count = pel_pkg::COUNT_W'(1);
		end else if (count_q > pel_pkg::COUNT_MAX) begin
			eff_count = pel_pkg::COUNT_MAX;
		end else begin
			eff_count = count_q;
		end
		pos_inc = {1'b0, pos_q} + pel_pkg::COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			if (last_in || (pos_inc >= eff_count)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[pel_pkg::POS_W-1:0];
			end
		end
	end

	// capture the item
	logic signed [SW-1:0]        s_q;
	logic                        last_q;
	logic [pel_pkg::POS_W-1:0]   chan_q;
	logic                        in_range_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			s_q        <= sample_in;
			last_q     <= last_in;
			chan_q     <= pos_q;
			in_range_q <= ({1'b0, pos_q} < pel_pkg::COUNT_W'(MAX_CHANNELS));
		end
	end

	// envelope store, cleared by reset or by the clear flag
	logic [SW-1:0] env_q [MAX_CHANNELS];
	logic [SW-1:0] env_new;
	logic [IDX_W-1:0] idx;

	assign idx = chan_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				env_q[i] <= '0;
			end
		end else if (cmd.accept && clear_in) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				env_q[i] <= '0;
			end
		end else if (cmd.upd && in_range_q) begin
			env_q[idx] <= env_new;
		end
	end

	// load: level, old envelope, coefficient choice
	logic [SW-1:0]          level_w;
	logic [SW-1:0]          env_rd;
	logic [CW-1:0]          att_c;
	logic [CW-1:0]          rel_c;
	logic [SW-1:0]          env_old_q;
	logic signed [SW:0]     diff_q;
	logic [CW-1:0]          coeff_q;

	always_comb begin
		level_w = s_q[SW-1] ? (~s_q + SW'(1)) : s_q;
		env_rd  = in_range_q ? env_q[idx] : '0;
		att_c   = (attack_q > pel_pkg::ONE_Q16) ? pel_pkg::ONE_Q16 : attack_q;
		rel_c   = (release_q > pel_pkg::ONE_Q16) ? pel_pkg::ONE_Q16 : release_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			env_old_q <= env_rd;
			diff_q    <= $signed({1'b0, level_w}) - $signed({1'b0, env_rd});
			coeff_q   <= (level_w > env_rd) ? att_c : rel_c;
		end
	end

	// multiply the difference by the coefficient
	logic signed [SW+CW+1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= diff_q * $signed({1'b0, coeff_q});
		end
	end

	// update: floor shift, add, clamp
	logic signed [SW+2:0] step_w;
	logic signed [SW+2:0] env_sum;

	always_comb begin
		step_w  = prod_q[SW+CW+1:16];
		env_sum = $signed({3'b000, env_old_q}) + step_w;
		if (env_sum < 0) begin
			env_new = '0;
		end else if (env_sum > $signed({3'b000, {SW{1'b1}}})) begin
			env_new = {SW{1'b1}};
		end else begin
			env_new = env_sum[SW-1:0];
		end
	end

	assign sts.need_div = in_range_q && (env_new > ceiling_q);

	// restoring divider: gain = ceiling * 65536 / envelope, one bit a cycle
	logic [SW-1:0]               rem_q;
	logic [SW-1:0]               dvs_q;
	logic [pel_pkg::QUO_W-1:0]   quo_q;
	logic [pel_pkg::CNT_W-1:0]   div_cnt_q;
	logic                        use_div_q;
	logic [SW:0]                 rem_dbl;
	logic [SW:0]                 rem_sub;
	logic                        rem_ge;

	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_sub = rem_dbl - {1'b0, dvs_q};
		rem_ge  = (rem_dbl >= {1'b0, dvs_q});
	end

	assign sts.div_last = (div_cnt_q == pel_pkg::CNT_W'(pel_pkg::QUO_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			rem_q     <= ceiling_q;
			dvs_q     <= env_new;
			quo_q     <= '0;
			div_cnt_q <= '0;
			use_div_q <= sts.need_div;
		end else if (cmd.div_step) begin
			rem_q     <= rem_ge ? rem_sub[SW-1:0] : rem_dbl[SW-1:0];
			quo_q     <= {quo_q[pel_pkg::QUO_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + pel_pkg::CNT_W'(1);
		end
	end

	// apply the gain
	logic [CW-1:0]           gain_w;
	logic signed [SW+CW:0]   mul_q;

	assign gain_w = use_div_q ? {1'b0, quo_q} : pel_pkg::ONE_Q16;

	always_ff @(posedge clk) begin
		if (cmd.gmul) begin
			mul_q <= s_q * $signed({1'b0, gain_w});
		end
	end

	// round half up and saturate
	logic signed [SW+CW:0]   rnd_w;
	logic signed [SW+CW-16:0] shr_w;
	logic signed [SW-1:0]    sat_w;

	always_comb begin
		rnd_w = mul_q + (SW + CW + 1)'(32768);
		shr_w = rnd_w[SW+CW:16];
		if (shr_w > $signed({{(CW-16+1){1'b0}}, 1'b0, {(SW-1){1'b1}}})) begin
			sat_w = {1'b0, {(SW-1){1'b1}}};
		end else if (shr_w < $signed({{(CW-16+1){1'b1}}, 1'b1, {(SW-1){1'b0}}})) begin
			sat_w = {1'b1, {(SW-1){1'b0}}};
		end else begin
			sat_w = shr_w[SW-1:0];
		end
	end

	// output register: hold until taken
	logic out_valid_q;

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			sample_out <= sat_w;
			channel    <= chan_q;
			last_out   <= last_q;
		end
	end

endmodule
